>>> rtl/dds_srp_pkg.sv
// Shared constants and helpers for the DDS serial register port.
package dds_srp_pkg;

    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned REG_IDX_W = 3;   // eight register slots per channel

    // Register map addresses
    localparam logic [ADDR_W-1:0] ADDR_CSR       = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_FR1       = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_FR2       = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_CHAN_BASE = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_LAST      = 4'd10;

    localparam logic [7:0]  CSR_RESET = 8'hF2;
    localparam logic [31:0] CFR_RESET = 32'h0000_0300;

    // Instruction byte: bit 7 selects a read
    localparam int unsigned INSTR_READ_BIT = 7;

    // Register size in bytes by address; zero for addresses off the map
    function automatic logic [2:0] reg_size(input logic [ADDR_W-1:0] addr);
        logic [2:0] size;
        case (addr)
            4'd0:    size = 3'd1;
            4'd1:    size = 3'd3;
            4'd2:    size = 3'd2;
            4'd3:    size = 3'd3;
            4'd4:    size = 3'd4;
            4'd5:    size = 3'd2;
            4'd6:    size = 3'd3;
            4'd7:    size = 3'd2;
            4'd8:    size = 3'd4;
            4'd9:    size = 3'd4;
            4'd10:   size = 3'd4;
            default: size = 3'd0;
        endcase
        return size;
    endfunction

    function automatic logic [31:0] size_mask(input logic [2:0] size);
        logic [31:0] mask;
        case (size)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

>>> rtl/dds_serial_register_port.sv
// Top level of the DDS serial register port: framing, register file and result stage.
//
// Usage
//   Slave channel s_*: one serial byte per beat. s_tuser is the command
//   (0 = byte transfer, 1 = restart framing, data ignored); s_tdata is the byte.
//   Master channel m_*: exactly one result beat per input beat, in order,
//   carrying the read byte, read/write/bad-address flags and current address.
//   Path: a beat accepted into the input register is decoded from it
//   combinationally and shows on m_* once written into the result register.
//   Throughput: one beat per cycle while m_tready stays high; framing state,
//   the register file and the read snapshot all update when a beat is decoded,
//   so beats follow back to back with no gap.
//   Reset (rst_n low, asynchronous): framing returns to expecting an
//   instruction, CSR = 0xF2 (all channels enabled), FR1/FR2 clear, each
//   channel's CFR = 0x000300 and its other registers clear.
//   Stalls: while m_tready is low the result register holds its beat; the
//   input register still takes one more beat, then s_tready drops until
//   the result is taken.
//   Writes commit on the last data byte; reads snapshot the register when the
//   instruction arrives.
module dds_serial_register_port
    import dds_srp_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_byte, [8] read_valid, [9] write_done,
                                   // [13:10] reg_address, [14] bad_address, [15] zero
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic       cmd_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic       advance;
    logic       proc;

    // Result stage can take a new beat when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Framing state and register file
    // ------------------------------------------------------------------
    logic              in_data_phase_reg, in_data_phase_next;
    logic              read_mode_reg, read_mode_next;
    logic [ADDR_W-1:0] cur_address_reg, cur_address_next;
    logic [2:0]        bytes_left_reg, bytes_left_next;
    logic [31:0]       assembly_reg, assembly_next;

    logic [7:0]  csr_value_reg;
    logic [23:0] fr1_value_reg;
    logic [15:0] fr2_value_reg;
    logic [31:0] chan_reg [NUM_CHANNELS][2**REG_IDX_W];

    logic [ADDR_W-1:0]    instr_addr;
    logic [ADDR_W-1:0]    instr_off;
    logic [REG_IDX_W-1:0] instr_idx;
    logic [31:0]          chan_rd;
    logic [31:0]          fetch_val;

    logic                 commit_en;
    logic [31:0]          commit_val;
    logic [ADDR_W-1:0]    commit_off;
    logic [REG_IDX_W-1:0] commit_idx;

    logic [1:0]  shift_idx;
    logic [31:0] shifted;
    logic [7:0]  rbyte;
    logic        rvalid;
    logic        wdone;
    logic        bad;

    assign instr_addr = byte_reg[ADDR_W-1:0];
    assign instr_off  = instr_addr - ADDR_CHAN_BASE;
    assign instr_idx  = instr_off[REG_IDX_W-1:0];
    assign commit_off = cur_address_reg - ADDR_CHAN_BASE;
    assign commit_idx = commit_off[REG_IDX_W-1:0];

    // Read from the lowest enabled channel; zero when none is enabled
    always_comb
    begin
        chan_rd = '0;
        for (int ch = NUM_CHANNELS - 1; ch >= 0; ch--)
        begin
            if (csr_value_reg[4 + ch])
            begin
                chan_rd = chan_reg[ch][instr_idx];
            end
        end
    end

    always_comb
    begin
        case (instr_addr)
            ADDR_CSR: fetch_val = {24'd0, csr_value_reg};
            ADDR_FR1: fetch_val = {8'd0, fr1_value_reg};
            ADDR_FR2: fetch_val = {16'd0, fr2_value_reg};
            default:  fetch_val = chan_rd;
        endcase
    end

    // Byte to shift out: bits of the snapshot above the remaining count
    assign shift_idx = bytes_left_reg[1:0] - 2'd1;
    assign shifted   = assembly_reg >> {shift_idx, 3'b000};

    always_comb
    begin
        in_data_phase_next = in_data_phase_reg;
        read_mode_next     = read_mode_reg;
        cur_address_next   = cur_address_reg;
        bytes_left_next    = bytes_left_reg;
        assembly_next      = assembly_reg;
        commit_en          = 1'b0;
        commit_val         = '0;
        rbyte              = '0;
        rvalid             = 1'b0;
        wdone              = 1'b0;
        bad                = 1'b0;
        if (proc)
        begin
            if (cmd_reg)
            begin
                // restart framing, keep the address
                in_data_phase_next = 1'b0;
                read_mode_next     = 1'b0;
                bytes_left_next    = '0;
                assembly_next      = '0;
            end
            else if (!in_data_phase_reg)
            begin
                cur_address_next = instr_addr;
                if (instr_addr > ADDR_LAST)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    in_data_phase_next = 1'b1;
                    read_mode_next     = byte_reg[INSTR_READ_BIT];
                    bytes_left_next    = reg_size(instr_addr);
                    assembly_next      = byte_reg[INSTR_READ_BIT] ? fetch_val : 32'd0;
                end
            end
            else if (bytes_left_reg == 3'd0 || bytes_left_reg > 3'd4
                     || cur_address_reg > ADDR_LAST)
            begin
                // inconsistent framing: drop back to expecting an instruction
                in_data_phase_next = 1'b0;
                read_mode_next     = 1'b0;
                bytes_left_next    = '0;
            end
            else if (read_mode_reg)
            begin
                rbyte           = shifted[7:0];
                rvalid          = 1'b1;
                bytes_left_next = bytes_left_reg - 3'd1;
                if (bytes_left_reg == 3'd1)
                begin
                    in_data_phase_next = 1'b0;
                    read_mode_next     = 1'b0;
                end
            end
            else
            begin
                assembly_next   = {assembly_reg[23:0], byte_reg};
                bytes_left_next = bytes_left_reg - 3'd1;
                if (bytes_left_reg == 3'd1)
                begin
                    commit_en          = 1'b1;
                    commit_val         = assembly_next & size_mask(reg_size(cur_address_reg));
                    wdone              = 1'b1;
                    in_data_phase_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_data_phase_reg <= 1'b0;
            read_mode_reg     <= 1'b0;
            cur_address_reg   <= '0;
            bytes_left_reg    <= '0;
            assembly_reg      <= '0;
        end
        else
        begin
            in_data_phase_reg <= in_data_phase_next;
            read_mode_reg     <= read_mode_next;
            cur_address_reg   <= cur_address_next;
            bytes_left_reg    <= bytes_left_next;
            assembly_reg      <= assembly_next;
        end
    end

    // Register file: globals plus broadcast write to every enabled channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csr_value_reg <= CSR_RESET;
            fr1_value_reg <= '0;
            fr2_value_reg <= '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                for (int r = 0; r < 2**REG_IDX_W; r++)
                begin
                    chan_reg[ch][r] <= (r == 0) ? CFR_RESET : 32'd0;
                end
            end
        end
        else if (commit_en)
        begin
            case (cur_address_reg)
                ADDR_CSR: csr_value_reg <= commit_val[7:0];
                ADDR_FR1: fr1_value_reg <= commit_val[23:0];
                ADDR_FR2: fr2_value_reg <= commit_val[15:0];
                default:
                begin
                    for (int ch = 0; ch < NUM_CHANNELS; ch++)
                    begin
                        if (csr_value_reg[4 + ch])
                        begin
                            chan_reg[ch][commit_idx] <= commit_val;
                        end
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= {1'b0, bad, cur_address_next, wdone, rvalid, rbyte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A data phase always has bytes outstanding, and only a data phase does
    a_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_data_phase_reg == (bytes_left_reg != 3'd0))
        else $error("data phase and byte count disagree");

    // Read mode only exists inside a data phase
    a_read_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        read_mode_reg |-> in_data_phase_reg)
        else $error("read mode outside a data phase");

    // A processed restart leaves framing expecting an instruction
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && cmd_reg) |=> (!in_data_phase_reg && !read_mode_reg))
        else $error("restart did not clear framing");

    // A result beat never carries more than one kind of event
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({m_tdata[8], m_tdata[9], m_tdata[14]}))
        else $error("result beat flags overlap");

    // A commit only happens on a write data byte
    a_commit_write: assert property (@(posedge clk) disable iff (!rst_n)
        commit_en |-> (proc && in_data_phase_reg && !read_mode_reg && !cmd_reg))
        else $error("commit outside a write data byte");

endmodule
